// ----- sv/rlcu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcu_pkg
// Types, constants and the exp table shared by the logit cell update core.
// ----------------------------------------------------------------------------
package rlcu_pkg;

  localparam int NUM_STRAT = 3;
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW    = 8;

  localparam logic [1:0] STRAT_ROCK     = 2'd0;
  localparam logic [1:0] STRAT_PAPER    = 2'd1;
  localparam logic [1:0] STRAT_SCISSORS = 2'd2;
  localparam logic [1:0] STRAT_NONE     = 2'd3;

  localparam logic [1:0] CFG_ROW_ROCK     = 2'd0;
  localparam logic [1:0] CFG_ROW_PAPER    = 2'd1;
  localparam logic [1:0] CFG_ROW_SCISSORS = 2'd2;
  localparam logic [1:0] CFG_INV_TEMP     = 2'd3;

  localparam logic [23:0] ROW_ROCK_RST     = 24'hF01000;
  localparam logic [23:0] ROW_PAPER_RST    = 24'h1000F0;
  localparam logic [23:0] ROW_SCISSORS_RST = 24'h00F010;
  localparam logic [15:0] INV_TEMP_RST     = 16'h1000;

  localparam longint unsigned EXP_STEP_Q32 = 64'd4034748382;

  typedef logic signed [9:0] score_t;
  typedef logic [9:0]        dist_t;
  typedef logic [25:0]       arg_t;
  typedef logic [14:0]       idx_t;
  typedef logic [15:0]       weight_t;

  typedef struct packed {
    logic [1:0]        north_strategy;
    logic [1:0]        east_strategy;
    logic [1:0]        south_strategy;
    logic [1:0]        west_strategy;
    logic signed [15:0] random_sample;
  } in_t;

  typedef struct packed {
    logic [1:0] new_strategy;
    logic       bad_input;
  } out_t;

  typedef struct packed {
    logic [23:0] row_rock;
    logic [23:0] row_paper;
    logic [23:0] row_scissors;
    logic [15:0] inv_temperature;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               bad;
    logic signed [15:0] sample;
    dist_t [NUM_STRAT-1:0] gap;
  } dist_stage_t;

  typedef struct packed {
    logic               valid;
    logic               bad;
    logic signed [15:0] sample;
    weight_t [NUM_STRAT-1:0] w;
  } weight_stage_t;

  typedef logic [15:0] exp_rom_t [ROM_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        rom;
    longint unsigned e;
    longint unsigned q;
    e = 64'd1 << 32;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      q = (e + 64'd32768) >> 16;
      rom[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  function automatic logic signed [7:0] payoff(input logic [23:0] row, input logic [1:0] opp);
    logic signed [7:0] p;
    unique case (opp)
      STRAT_ROCK:     p = row[7:0];
      STRAT_PAPER:    p = row[15:8];
      STRAT_SCISSORS: p = row[23:16];
      STRAT_NONE:     p = 8'sd0;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/rlcu_score.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcu_score
// Two stages: payoff sums per own strategy, then distance from the best score.
// ----------------------------------------------------------------------------
module rlcu_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  rlcu_pkg::in_t        in_data,
  input  rlcu_pkg::cfg_t       cfg,
  output rlcu_pkg::dist_stage_t dist_out
);

  logic                 s1_valid_r;
  logic                 s1_bad_r;
  logic signed [15:0]   s1_sample_r;
  rlcu_pkg::score_t     s1_score_r [rlcu_pkg::NUM_STRAT];
  rlcu_pkg::score_t     score_nxt [rlcu_pkg::NUM_STRAT];
  logic [23:0]          rows [rlcu_pkg::NUM_STRAT];
  logic [1:0]           opp [4];
  rlcu_pkg::score_t     best;
  rlcu_pkg::dist_stage_t dist_r;
  rlcu_pkg::dist_stage_t dist_nxt;

  assign rows[0] = cfg.row_rock;
  assign rows[1] = cfg.row_paper;
  assign rows[2] = cfg.row_scissors;
  assign opp[0]  = in_data.north_strategy;
  assign opp[1]  = in_data.east_strategy;
  assign opp[2]  = in_data.south_strategy;
  assign opp[3]  = in_data.west_strategy;

  always_comb begin
    for (int s = 0; s < rlcu_pkg::NUM_STRAT; s++) begin
      score_nxt[s] = rlcu_pkg::score_t'(rlcu_pkg::payoff(rows[s], opp[0]))
                   + rlcu_pkg::score_t'(rlcu_pkg::payoff(rows[s], opp[1]))
                   + rlcu_pkg::score_t'(rlcu_pkg::payoff(rows[s], opp[2]))
                   + rlcu_pkg::score_t'(rlcu_pkg::payoff(rows[s], opp[3]));
    end
  end

  always_comb begin
    best = s1_score_r[0];
    if (s1_score_r[1] > best) begin
      best = s1_score_r[1];
    end
    if (s1_score_r[2] > best) begin
      best = s1_score_r[2];
    end
    dist_nxt.valid  = s1_valid_r;
    dist_nxt.bad    = s1_bad_r;
    dist_nxt.sample = s1_sample_r;
    for (int s = 0; s < rlcu_pkg::NUM_STRAT; s++) begin
      dist_nxt.gap[s] = rlcu_pkg::dist_t'(best - s1_score_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      dist_r.valid <= 1'b0;
    end else begin
      s1_valid_r   <= in_fire;
      dist_r.valid <= dist_nxt.valid;
    end
    s1_bad_r      <= (opp[0] == rlcu_pkg::STRAT_NONE) || (opp[1] == rlcu_pkg::STRAT_NONE)
                  || (opp[2] == rlcu_pkg::STRAT_NONE) || (opp[3] == rlcu_pkg::STRAT_NONE);
    s1_sample_r   <= in_data.random_sample;
    s1_score_r    <= score_nxt;
    dist_r.bad    <= dist_nxt.bad;
    dist_r.sample <= dist_nxt.sample;
    dist_r.gap    <= dist_nxt.gap;
  end

  assign dist_out = dist_r;

endmodule

// ----- sv/rlcu_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcu_weight
// Two stages: distance times inverse temperature, then rounding and exp lookup.
// ----------------------------------------------------------------------------
module rlcu_weight #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            inv_temperature,
  input  rlcu_pkg::dist_stage_t  dist_in,
  output rlcu_pkg::weight_stage_t weight_out
);

  localparam int LUT_DEPTH = (EXP_TABLE_DEPTH < rlcu_pkg::ROM_DEPTH) ?
                             EXP_TABLE_DEPTH : rlcu_pkg::ROM_DEPTH;

  logic                    s3_valid_r;
  logic                    s3_bad_r;
  logic signed [15:0]      s3_sample_r;
  rlcu_pkg::arg_t          s3_arg_r [rlcu_pkg::NUM_STRAT];
  rlcu_pkg::arg_t          arg_nxt [rlcu_pkg::NUM_STRAT];
  rlcu_pkg::idx_t          idx [rlcu_pkg::NUM_STRAT];
  rlcu_pkg::weight_stage_t weight_r;
  rlcu_pkg::weight_stage_t weight_nxt;

  always_comb begin
    for (int s = 0; s < rlcu_pkg::NUM_STRAT; s++) begin
      arg_nxt[s] = rlcu_pkg::arg_t'(dist_in.gap[s]) * rlcu_pkg::arg_t'(inv_temperature);
    end
  end

  always_comb begin
    weight_nxt.valid  = s3_valid_r;
    weight_nxt.bad    = s3_bad_r;
    weight_nxt.sample = s3_sample_r;
    for (int s = 0; s < rlcu_pkg::NUM_STRAT; s++) begin
      idx[s] = rlcu_pkg::idx_t'((27'(s3_arg_r[s]) + 27'd2048) >> 12);
      if (idx[s] < rlcu_pkg::idx_t'(LUT_DEPTH)) begin
        weight_nxt.w[s] = rlcu_pkg::EXP_ROM[idx[s][rlcu_pkg::ROM_AW-1:0]];
      end else begin
        weight_nxt.w[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r     <= 1'b0;
      weight_r.valid <= 1'b0;
    end else begin
      s3_valid_r     <= dist_in.valid;
      weight_r.valid <= weight_nxt.valid;
    end
    s3_bad_r        <= dist_in.bad;
    s3_sample_r     <= dist_in.sample;
    s3_arg_r        <= arg_nxt;
    weight_r.bad    <= weight_nxt.bad;
    weight_r.sample <= weight_nxt.sample;
    weight_r.w      <= weight_nxt.w;
  end

  assign weight_out = weight_r;

endmodule

// ----- sv/rlcu_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcu_decide
// Three stages: weight sums, scaled sample and thresholds, final comparison.
// ----------------------------------------------------------------------------
module rlcu_decide (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rlcu_pkg::weight_stage_t weight_in,
  output logic                    out_valid,
  output rlcu_pkg::out_t          out_data
);

  logic               s5_valid_r;
  logic               s5_bad_r;
  logic signed [15:0] s5_sample_r;
  logic [17:0]        s5_sum_r;
  logic [15:0]        s5_w0_r;
  logic [16:0]        s5_w01_r;

  logic               s6_valid_r;
  logic               s6_bad_r;
  logic signed [33:0] s6_lhs_r;
  logic [27:0]        s6_thr0_r;
  logic [28:0]        s6_thr1_r;

  logic               out_valid_r;
  rlcu_pkg::out_t     out_data_r;
  rlcu_pkg::out_t     out_data_nxt;

  always_comb begin
    out_data_nxt.bad_input = s6_bad_r;
    if (s6_lhs_r < $signed({6'd0, s6_thr0_r})) begin
      out_data_nxt.new_strategy = rlcu_pkg::STRAT_ROCK;
    end else if (s6_lhs_r > $signed({5'd0, s6_thr1_r})) begin
      out_data_nxt.new_strategy = rlcu_pkg::STRAT_SCISSORS;
    end else begin
      out_data_nxt.new_strategy = rlcu_pkg::STRAT_PAPER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s5_valid_r  <= weight_in.valid;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r;
    end
    s5_bad_r    <= weight_in.bad;
    s5_sample_r <= weight_in.sample;
    s5_sum_r    <= 18'(weight_in.w[0]) + 18'(weight_in.w[1]) + 18'(weight_in.w[2]);
    s5_w0_r     <= weight_in.w[0];
    s5_w01_r    <= 17'(weight_in.w[0]) + 17'(weight_in.w[1]);
    s6_bad_r    <= s5_bad_r;
    s6_lhs_r    <= 34'(s5_sample_r) * 34'($signed({1'b0, s5_sum_r}));
    s6_thr0_r   <= {s5_w0_r, 12'd0};
    s6_thr1_r   <= {s5_w01_r, 12'd0};
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/rps_logit_cell_update_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_logit_cell_update_core
// Logit-choice strategy update of one rock-paper-scissors cell.
// ----------------------------------------------------------------------------
// A result is transferred once its command has passed the score, weight and decide stages.
// Throughput: one cell per cycle, set by the seven-stage pipeline; busy stays low.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous reset clears all valid bits and restores the payoff matrix and
// inverse temperature to their defaults; no results are pending after reset.
module rps_logit_cell_update_core #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rlcu_pkg::in_t  in_data,
  output logic           out_valid,
  output rlcu_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [23:0]    cfg_data
);

  localparam int LATENCY = 7;

  rlcu_pkg::cfg_t          cfg_r;
  rlcu_pkg::dist_stage_t   dist_s;
  rlcu_pkg::weight_stage_t weight_s;
  logic                    in_fire;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_rock        <= rlcu_pkg::ROW_ROCK_RST;
      cfg_r.row_paper       <= rlcu_pkg::ROW_PAPER_RST;
      cfg_r.row_scissors    <= rlcu_pkg::ROW_SCISSORS_RST;
      cfg_r.inv_temperature <= rlcu_pkg::INV_TEMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rlcu_pkg::CFG_ROW_ROCK:     cfg_r.row_rock        <= cfg_data;
        rlcu_pkg::CFG_ROW_PAPER:    cfg_r.row_paper       <= cfg_data;
        rlcu_pkg::CFG_ROW_SCISSORS: cfg_r.row_scissors    <= cfg_data;
        rlcu_pkg::CFG_INV_TEMP:     cfg_r.inv_temperature <= cfg_data[15:0];
      endcase
    end
  end

  rlcu_score u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .dist_out (dist_s)
  );

  rlcu_weight #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_weight (
    .clk             (clk),
    .rst_n           (rst_n),
    .inv_temperature (cfg_r.inv_temperature),
    .dist_in         (dist_s),
    .weight_out      (weight_s)
  );

  rlcu_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .weight_in (weight_s),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("command transfer without a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("result without a command transfer");

  a_strategy_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.new_strategy != rlcu_pkg::STRAT_NONE)
    else $error("invalid strategy code in result");

  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bad_input == $past(
      (in_data.north_strategy == rlcu_pkg::STRAT_NONE) ||
      (in_data.east_strategy == rlcu_pkg::STRAT_NONE) ||
      (in_data.south_strategy == rlcu_pkg::STRAT_NONE) ||
      (in_data.west_strategy == rlcu_pkg::STRAT_NONE), LATENCY))
    else $error("bad_input does not match the neighbor codes");
`endif

endmodule

// ----- tb/sv/tb_rps_logit_cell_update_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rps_logit_cell_update_core
// Self-checking testbench for the logit-choice rock-paper-scissors cell update.
// A short table of directed cells comes first: all-invalid neighbors at the
// decision boundaries, uniform neighborhoods and the extremes of the sample.
// Random cells then run under several payoff matrices and inverse
// temperatures, including zero and full-scale values. Every result is compared
// against a table entry or an in-bench score, exp-weight and threshold calculation.
// ----------------------------------------------------------------------------
module tb_rps_logit_cell_update_core;
  import rlcu_pkg::*;

  localparam int PHASES     = 6;
  localparam int PHASE_SIZE = 75;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t result;
  } directed_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_t         in_data   = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ROW_ROCK;
  logic [23:0] cfg_data  = '0;

  cfg_t        settings;
  logic [15:0] exp_weights [ROM_DEPTH];
  out_t        pending_updates [$];
  int          mismatch_count = 0;
  int          cells_sent     = 0;
  int          updates_seen   = 0;
  int          invalid_seen   = 0;
  int          reg_writes     = 0;
  int          strategy_seen [3] = '{0, 0, 0};

  directed_row_t directed_rows [20] = '{
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sh8000}, 1'b1, '{STRAT_ROCK, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sh7FFF}, 1'b1,
      '{STRAT_SCISSORS, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sd0}, 1'b1, '{STRAT_ROCK, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sd1365}, 1'b1, '{STRAT_ROCK, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sd1366}, 1'b1, '{STRAT_PAPER, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sd2730}, 1'b1, '{STRAT_PAPER, 1'b1}},
    '{'{STRAT_NONE, STRAT_NONE, STRAT_NONE, STRAT_NONE, 16'sd2731}, 1'b1,
      '{STRAT_SCISSORS, 1'b1}},
    '{'{STRAT_ROCK, STRAT_ROCK, STRAT_ROCK, STRAT_ROCK, 16'sh8000}, 1'b1, '{STRAT_ROCK, 1'b0}},
    '{'{STRAT_PAPER, STRAT_PAPER, STRAT_PAPER, STRAT_PAPER, 16'sh7FFF}, 1'b1,
      '{STRAT_SCISSORS, 1'b0}},
    '{'{STRAT_SCISSORS, STRAT_SCISSORS, STRAT_SCISSORS, STRAT_SCISSORS, 16'sd0}, 1'b0, '0},
    '{'{STRAT_ROCK, STRAT_ROCK, STRAT_ROCK, STRAT_ROCK, 16'sd2048}, 1'b0, '0},
    '{'{STRAT_PAPER, STRAT_PAPER, STRAT_PAPER, STRAT_PAPER, 16'sd2048}, 1'b0, '0},
    '{'{STRAT_NONE, STRAT_ROCK, STRAT_PAPER, STRAT_SCISSORS, 16'sd4096}, 1'b0, '0},
    '{'{STRAT_ROCK, STRAT_NONE, STRAT_SCISSORS, STRAT_PAPER, 16'sd1000}, 1'b0, '0},
    '{'{STRAT_SCISSORS, STRAT_PAPER, STRAT_NONE, STRAT_ROCK, 16'sd3000}, 1'b0, '0},
    '{'{STRAT_PAPER, STRAT_SCISSORS, STRAT_ROCK, STRAT_NONE, 16'sd4095}, 1'b0, '0},
    '{'{STRAT_ROCK, STRAT_PAPER, STRAT_ROCK, STRAT_PAPER, 16'sd1}, 1'b0, '0},
    '{'{STRAT_SCISSORS, STRAT_SCISSORS, STRAT_ROCK, STRAT_ROCK, -16'sd1}, 1'b0, '0},
    '{'{STRAT_PAPER, STRAT_PAPER, STRAT_SCISSORS, STRAT_SCISSORS, 16'sh7FFF}, 1'b1,
      '{STRAT_SCISSORS, 1'b0}},
    '{'{STRAT_SCISSORS, STRAT_SCISSORS, STRAT_SCISSORS, STRAT_SCISSORS, 16'sh8000}, 1'b1,
      '{STRAT_ROCK, 1'b0}}
  };

  rps_logit_cell_update_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_rps_logit_cell_update_core NOT OK");
    $finish;
  end

  task automatic build_exp_weights();
    longint unsigned e;
    longint unsigned q;
    e = 64'd1 << 32;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      q = (e + 64'd32768) >> 16;
      exp_weights[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
  endtask

  function automatic out_t predict_update(in_t c);
    logic [1:0]        opp [4];
    logic [23:0]       row [3];
    logic signed [7:0] p;
    int                score [3];
    int                best;
    longint            w [3];
    longint            arg;
    longint            idx;
    longint            total;
    longint            lhs;
    out_t              r;
    opp = '{c.north_strategy, c.east_strategy, c.south_strategy, c.west_strategy};
    row = '{settings.row_rock, settings.row_paper, settings.row_scissors};
    r.bad_input = 1'b0;
    score = '{0, 0, 0};
    for (int n = 0; n < 4; n++) begin
      if (opp[n] == STRAT_NONE) begin
        r.bad_input = 1'b1;
      end else begin
        for (int s = 0; s < NUM_STRAT; s++) begin
          p = row[s][8 * opp[n] +: 8];
          score[s] += p;
        end
      end
    end
    best = score[0];
    if (score[1] > best) best = score[1];
    if (score[2] > best) best = score[2];
    for (int s = 0; s < NUM_STRAT; s++) begin
      arg = longint'(best - score[s]) * longint'(settings.inv_temperature);
      idx = (arg + 2048) >>> 12;
      w[s] = (idx < ROM_DEPTH) ? longint'(exp_weights[idx]) : 0;
    end
    total = w[0] + w[1] + w[2];
    lhs = longint'(c.random_sample) * total;
    r.new_strategy = STRAT_PAPER;
    if (lhs < w[0] * 4096) r.new_strategy = STRAT_ROCK;
    if (lhs > (w[0] + w[1]) * 4096) r.new_strategy = STRAT_SCISSORS;
    return r;
  endfunction

  function automatic logic [1:0] random_neighbor();
    logic [1:0] code;
    if ($urandom_range(0, 9) == 0) code = STRAT_NONE;
    else code = 2'($urandom_range(0, 2));
    return code;
  endfunction

  function automatic in_t random_cell();
    in_t c;
    int  pick;
    c.north_strategy = random_neighbor();
    c.east_strategy  = random_neighbor();
    c.south_strategy = random_neighbor();
    c.west_strategy  = random_neighbor();
    pick = $urandom_range(0, 19);
    if (pick < 11) c.random_sample = 16'($urandom_range(0, 4096));
    else if (pick < 15) c.random_sample = 16'($urandom_range(0, 4224)) - 16'sd64;
    else c.random_sample = 16'($urandom());
    return c;
  endfunction

  // The cell is transferred at the first edge with start high and busy low.
  task automatic send_cell(in_t c, bit typed, out_t result);
    out_t upd;
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    upd = typed ? result : predict_update(c);
    pending_updates.insert(pending_updates.size(), upd);
    cells_sent++;
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_updates();
    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_ROW_ROCK:     settings.row_rock = value;
      CFG_ROW_PAPER:    settings.row_paper = value;
      CFG_ROW_SCISSORS: settings.row_scissors = value;
      CFG_INV_TEMP:     settings.inv_temperature = value[15:0];
    endcase
    reg_writes++;
  endtask

  task automatic load_settings(logic [23:0] rock, logic [23:0] paper,
                               logic [23:0] scissors, logic [23:0] temp);
    write_reg(CFG_ROW_ROCK, rock);
    write_reg(CFG_ROW_PAPER, paper);
    write_reg(CFG_ROW_SCISSORS, scissors);
    write_reg(CFG_INV_TEMP, temp);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_cells(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_cell(random_cell(), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 9));
    end
  endtask

  always @(posedge clk) begin : check_updates
    out_t expd;
    if (rst_n && out_valid) begin
      updates_seen++;
      if (out_data.bad_input) invalid_seen++;
      if (out_data.new_strategy <= STRAT_SCISSORS) strategy_seen[out_data.new_strategy]++;
      if (pending_updates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected update transfer: strategy %0d bad %0b",
                   out_data.new_strategy, out_data.bad_input);
      end else begin
        expd = pending_updates.pop_front();
        if (out_data.new_strategy !== expd.new_strategy ||
            out_data.bad_input !== expd.bad_input) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Update %0d mismatch: strategy %0d/%0d bad %0b/%0b (expected/actual)",
                     updates_seen, expd.new_strategy, out_data.new_strategy,
                     expd.bad_input, out_data.bad_input);
        end
      end
    end
  end

  initial begin
    build_exp_weights();
    settings = '{ROW_ROCK_RST, ROW_PAPER_RST, ROW_SCISSORS_RST, INV_TEMP_RST};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cell(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].result);
      if ($urandom_range(0, 1) != 0) pause_sender($urandom_range(1, 3));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_updates();
      case (ph)
        0: load_settings(ROW_ROCK_RST, ROW_PAPER_RST, ROW_SCISSORS_RST, 24'h000000);
        1: load_settings(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'hFFFFFF);
        2: load_settings(24'h7F7F7F, 24'h808080, 24'h7F8000, 24'h000001);
        3: load_settings(24'h808080, 24'h7F7F7F, 24'h00807F, 24'($urandom_range(4096, 65535)));
        default: load_settings(24'($urandom()), 24'($urandom()), 24'($urandom()),
                               {8'($urandom()), 16'($urandom_range(0, 8191))});
      endcase
      run_random_cells(PHASE_SIZE / 2);
      if (ph == 0) drain_updates();
      run_random_cells(PHASE_SIZE - PHASE_SIZE / 2);
    end

    drain_updates();
    repeat (12) @(posedge clk);
    $display("Covered %0d cells (%0d with an invalid neighbor) over %0d register writes.",
             cells_sent, invalid_seen, reg_writes);
    $display("Chosen strategies: rock %0d, paper %0d, scissors %0d; %0d mismatches.",
             strategy_seen[0], strategy_seen[1], strategy_seen[2], mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_rps_logit_cell_update_core OK");
    end else begin
      $display("tb_rps_logit_cell_update_core NOT OK");
    end
    $finish;
  end

endmodule
